### rtl/lkers_pkg.sv
// lkers_pkg: shared widths, operation and status codes, register indexes and word types
// for the sorted key table search unit
// no dependencies
`default_nettype none

package lkers_pkg;

	// default parameter values
	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_MAX_DIMS    = 8;

	// fixed field widths
	localparam int OP_W        = 2;
	localparam int KEY_W       = 64;
	localparam int COORD_W     = 32;
	localparam int WEIGHT_W    = 63;
	localparam int DIMS_W      = 4;
	localparam int STATUS_W    = 2;
	localparam int RES_W       = 11;
	localparam int PROD_W      = 2 * COORD_W;
	localparam int COORD_PORTS = 8;
	localparam int NUM_WEIGHTS = 7;
	localparam int CFG_IDX_W   = 3;

	// depth of the command queue between front and back
	localparam int CMD_DEPTH   = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_APPEND      = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY_KEY   = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY_COORD = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR       = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ANSWERED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIMS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0 = 3'd1;

	// command word from front to back
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
	} cmd_t;

	// result word
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [RES_W-1:0]    equal_count;
		logic [RES_W-1:0]    first_index;
	} res_t;

endpackage

`default_nettype wire

### rtl/lkers_ram.sv
// lkers_ram: generic memory, one write port and two read ports with registered read data
// no dependencies
`default_nettype none

module lkers_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

### rtl/lkers_front.sv
// lkers_front: accepts input words, holds the configuration registers and forms the
// search key from coordinates with one shared 32x32 multiplier; depends on lkers_pkg
`default_nettype none

module lkers_front import lkers_pkg::*; #(
	parameter int MAX_DIMS = DEF_MAX_DIMS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WEIGHT_W-1:0]  cfg_data,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [OP_W-1:0]      op,
	input  wire logic [KEY_W-1:0]     key_value,
	input  wire logic [COORD_W-1:0]   coord [COORD_PORTS],
	output logic                      cmd_push,
	output cmd_t                      cmd,
	input  wire logic                 cmd_full
);

	localparam int STEP_W = $clog2(2 * MAX_DIMS + 1);
	localparam int HALF_W = COORD_W;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MUL  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]          state_q;
	logic [DIMS_W-1:0]   dims_q;
	logic [WEIGHT_W-1:0] weights_q [NUM_WEIGHTS];
	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [COORD_W-1:0]  coords_q [MAX_DIMS];
	logic [STEP_W-1:0]   step_q;
	logic [KEY_W-1:0]    acc_q;
	logic [PROD_W-1:0]   prod_s1;
	logic                half_s1;
	logic                pv_s1;

	logic                accept;
	logic [DIMS_W-1:0]   dims_eff;
	logic [STEP_W-1:0]   total;
	logic [STEP_W-2:0]   dim_idx;
	logic                last_dim;
	logic [COORD_W-1:0]  c_sel;
	logic [WEIGHT_W-1:0] w_sel;
	logic [WEIGHT_W-1:0] w_eff;
	logic [HALF_W-1:0]   w_half;
	logic [PROD_W-1:0]   prod;
	logic                issue;
	logic                mul_done;

	assign full   = (state_q != F_IDLE);
	assign accept = push && !full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= '0;
			for (int i = 0; i < NUM_WEIGHTS; i++) begin
				weights_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_DIMS) begin
				dims_q <= cfg_data[DIMS_W-1:0];
			end
			for (int i = 0; i < NUM_WEIGHTS; i++) begin
				if (cfg_index == REG_WEIGHT_0 + CFG_IDX_W'(i)) begin
					weights_q[i] <= cfg_data;
				end
			end
		end
	end

	// dimensions in use, saturated; two partial products per dimension
	assign dims_eff = (dims_q > DIMS_W'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : dims_q;
	assign total    = STEP_W'({dims_eff, 1'b0});
	assign dim_idx  = step_q[STEP_W-1:1];
	assign last_dim = (DIMS_W'(dim_idx) + DIMS_W'(1)) == dims_eff;
	assign issue    = (state_q == F_MUL) && (step_q != total);
	assign mul_done = (state_q == F_MUL) && (step_q == total) && !pv_s1;

	// operand selection for the current dimension
	always_comb begin
		c_sel = '0;
		w_sel = '0;
		for (int i = 0; i < MAX_DIMS; i++) begin
			if (dim_idx == (STEP_W-1)'(i)) begin
				c_sel = coords_q[i];
			end
		end
		for (int i = 0; i < NUM_WEIGHTS; i++) begin
			if (i < MAX_DIMS && dim_idx == (STEP_W-1)'(i)) begin
				w_sel = weights_q[i];
			end
		end
	end

	// last dimension in use has unit stride; low half then high half of the weight
	assign w_eff  = last_dim ? WEIGHT_W'(1) : w_sel;
	assign w_half = step_q[0] ? HALF_W'(w_eff[WEIGHT_W-1:HALF_W]) : w_eff[HALF_W-1:0];
	assign prod   = PROD_W'(c_sel) * PROD_W'(w_half);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
			pv_s1   <= 1'b0;
		end else begin
			pv_s1 <= issue;
			unique case (state_q)
				F_IDLE: begin
					step_q <= '0;
					if (accept) begin
						state_q <= (op == OP_QUERY_COORD) ? F_MUL : F_PUSH;
					end
				end
				F_MUL: begin
					if (issue) begin
						step_q <= step_q + STEP_W'(1);
					end
					if (mul_done) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!cmd_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// held word, product stage and key accumulator
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			key_q <= key_value;
			acc_q <= '0;
			for (int i = 0; i < MAX_DIMS; i++) begin
				coords_q[i] <= coord[i];
			end
		end else if (pv_s1) begin
			acc_q <= acc_q + (half_s1 ? {prod_s1[HALF_W-1:0], {HALF_W{1'b0}}} : prod_s1);
		end
		prod_s1 <= prod;
		half_s1 <= step_q[0];
	end

	// command towards the back
	assign cmd_push = (state_q == F_PUSH) && !cmd_full;
	assign cmd.op   = (op_q == OP_QUERY_COORD) ? OP_QUERY_KEY : op_q;
	assign cmd.key  = (op_q == OP_QUERY_COORD) ? acc_q : key_q;

endmodule

`default_nettype wire

### rtl/lkers_cmd_fifo.sv
// lkers_cmd_fifo: short command queue between front and back
// depends on lkers_pkg
`default_nettype none

module lkers_cmd_fifo import lkers_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cmd_t wr_cmd,
	output logic      wr_full,
	input  wire logic rd_en,
	output cmd_t      rd_cmd,
	output logic      rd_valid
);

	localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMD_DEPTH + 1);

	cmd_t             slots_q [CMD_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_full  = (cnt_q == CNT_W'(CMD_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign do_wr    = wr_en && !wr_full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_cmd   = slots_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wptr_q] <= wr_cmd;
		end
	end

endmodule

`default_nettype wire

### rtl/lkers_back.sv
// lkers_back: key table, append and clear, two parallel bound searches and the result register
// depends on lkers_pkg and lkers_ram
`default_nettype none

module lkers_back import lkers_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	output logic      res_valid,
	output res_t      res,
	input  wire logic res_pop
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic B_IDLE   = 1'b0;
	localparam logic B_SEARCH = 1'b1;

	logic             state_q;
	logic             state_d;
	logic [CW-1:0]    kc_q;
	logic [CW-1:0]    kc_d;
	logic [KEY_W-1:0] key_q;
	logic             out_valid_q;
	res_t             res_q;
	res_t             res_d;
	logic             res_load;
	logic             slot_free;
	logic             start;
	logic             ram_we;

	// lower-bound (l) and upper-bound (u) search windows
	logic [CW-1:0]    lo_l_q, hi_l_q, lo_u_q, hi_u_q;
	logic [CW-1:0]    lo_l_d, hi_l_d, lo_u_d, hi_u_d;
	logic [CW-1:0]    mid_l_q, mid_u_q, mid_l_d, mid_u_d;
	logic [CW-1:0]    match;
	logic [KEY_W-1:0] rd_l, rd_u;
	logic             busy_l, busy_u;
	logic             done;

	assign slot_free = !out_valid_q || res_pop;
	assign busy_l    = lo_l_q < hi_l_q;
	assign busy_u    = lo_u_q < hi_u_q;
	assign done      = !busy_l && !busy_u;
	assign mid_l_q   = lo_l_q + ((hi_l_q - lo_l_q) >> 1);
	assign mid_u_q   = lo_u_q + ((hi_u_q - lo_u_q) >> 1);
	assign match     = (hi_u_q > lo_l_q) ? hi_u_q - lo_l_q : '0;

	// command decode and result formation
	always_comb begin
		state_d  = state_q;
		kc_d     = kc_q;
		cmd_pop  = 1'b0;
		res_load = 1'b0;
		start    = 1'b0;
		ram_we   = 1'b0;
		res_d    = '0;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op) inside
						OP_APPEND: begin
							if (slot_free) begin
								cmd_pop           = 1'b1;
								res_load          = 1'b1;
								res_d.first_index = RES_W'(kc_q);
								if (kc_q < CW'(TABLE_DEPTH)) begin
									ram_we       = 1'b1;
									kc_d         = kc_q + CW'(1);
									res_d.status = ST_APPENDED;
								end else begin
									res_d.status = ST_DROPPED;
								end
							end
						end
						OP_CLEAR: begin
							if (slot_free) begin
								cmd_pop      = 1'b1;
								res_load     = 1'b1;
								kc_d         = '0;
								res_d.status = ST_CLEARED;
							end
						end
						OP_QUERY_KEY, OP_QUERY_COORD: begin
							cmd_pop = 1'b1;
							start   = 1'b1;
							state_d = B_SEARCH;
						end
					endcase
				end
			end
			B_SEARCH: begin
				if (done && slot_free) begin
					res_load          = 1'b1;
					res_d.status      = ST_ANSWERED;
					res_d.equal_count = RES_W'(match);
					res_d.first_index = RES_W'(lo_l_q);
					state_d           = B_IDLE;
				end
			end
		endcase
	end

	// one probe per cycle for each search; address follows the next window
	always_comb begin
		lo_l_d = lo_l_q;
		hi_l_d = hi_l_q;
		lo_u_d = lo_u_q;
		hi_u_d = hi_u_q;
		if (start) begin
			lo_l_d = '0;
			hi_l_d = kc_q;
			lo_u_d = '0;
			hi_u_d = kc_q;
		end else if (state_q == B_SEARCH) begin
			if (busy_l) begin
				if ($signed(rd_l) < $signed(key_q)) begin
					lo_l_d = mid_l_q + CW'(1);
				end else begin
					hi_l_d = mid_l_q;
				end
			end
			if (busy_u) begin
				if (!($signed(key_q) < $signed(rd_u))) begin
					lo_u_d = mid_u_q + CW'(1);
				end else begin
					hi_u_d = mid_u_q;
				end
			end
		end
	end

	assign mid_l_d = lo_l_d + ((hi_l_d - lo_l_d) >> 1);
	assign mid_u_d = lo_u_d + ((hi_u_d - lo_u_d) >> 1);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			kc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kc_q    <= kc_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (res_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// search windows, key and result word
	always_ff @(posedge clk) begin
		lo_l_q <= lo_l_d;
		hi_l_q <= hi_l_d;
		lo_u_q <= lo_u_d;
		hi_u_q <= hi_u_d;
		if (start) begin
			key_q <= cmd.key;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// key table
	lkers_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (kc_q[AW-1:0]),
		.wdata   (cmd.key),
		.raddr_a (mid_l_d[AW-1:0]),
		.rdata_a (rd_l),
		.raddr_b (mid_u_d[AW-1:0]),
		.rdata_b (rd_u)
	);

	assign res_valid = out_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

### rtl/linear_key_equal_range_search_unit.sv
// linear_key_equal_range_search_unit: top level of the sorted key table search unit
// depends on lkers_pkg, lkers_front, lkers_cmd_fifo, lkers_back
//
//  channel   handshake          payload
//  config    cfg_we             cfg_index, cfg_data
//  input     push / full        op, key_value, coord_0 .. coord_7
//  result    pop / empty        status, equal_count, first_index
//
// append and clear: held in the front, queued, then loaded into the result register
// key query: answered by the two bound searches that probe the table in parallel,
// one probe per cycle each on the two read ports
// coordinate query: two partial products per used dimension on the shared 32x32 multiplier;
// front and back overlap, so a stream settles at the slower of the two
// reset clears the key count and the configuration; table contents stay undefined
// a waiting result word stops the front only once the command queue fills; the back stalls only when it holds one
`default_nettype none

module linear_key_equal_range_search_unit import lkers_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int MAX_DIMS    = DEF_MAX_DIMS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WEIGHT_W-1:0]  cfg_data,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [OP_W-1:0]      op,
	input  wire logic signed [KEY_W-1:0] key_value,
	input  wire logic [COORD_W-1:0]   coord_0,
	input  wire logic [COORD_W-1:0]   coord_1,
	input  wire logic [COORD_W-1:0]   coord_2,
	input  wire logic [COORD_W-1:0]   coord_3,
	input  wire logic [COORD_W-1:0]   coord_4,
	input  wire logic [COORD_W-1:0]   coord_5,
	input  wire logic [COORD_W-1:0]   coord_6,
	input  wire logic [COORD_W-1:0]   coord_7,
	output logic                      empty,
	input  wire logic                 pop,
	output logic [STATUS_W-1:0]       status,
	output logic [RES_W-1:0]          equal_count,
	output logic [RES_W-1:0]          first_index
);

	logic [COORD_W-1:0] coord [COORD_PORTS];
	logic               f_push;
	cmd_t               f_cmd;
	logic               q_full;
	logic               q_valid;
	cmd_t               q_cmd;
	logic               b_pop;
	logic               res_valid;
	res_t               res;
	logic               res_pop;

	assign coord[0] = coord_0;
	assign coord[1] = coord_1;
	assign coord[2] = coord_2;
	assign coord[3] = coord_3;
	assign coord[4] = coord_4;
	assign coord[5] = coord_5;
	assign coord[6] = coord_6;
	assign coord[7] = coord_7;

	// front: intake, configuration, key formation
	lkers_front #(
		.MAX_DIMS (MAX_DIMS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.op        (op),
		.key_value (key_value),
		.coord     (coord),
		.cmd_push  (f_push),
		.cmd       (f_cmd),
		.cmd_full  (q_full)
	);

	// command queue
	lkers_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (f_push),
		.wr_cmd   (f_cmd),
		.wr_full  (q_full),
		.rd_en    (b_pop),
		.rd_cmd   (q_cmd),
		.rd_valid (q_valid)
	);

	// back: table and searches
	lkers_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (b_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_pop   (res_pop)
	);

	// result port
	assign res_pop     = pop && res_valid;
	assign empty       = !res_valid;
	assign status      = res.status;
	assign equal_count = res.equal_count;
	assign first_index = res.first_index;

endmodule

`default_nettype wire

### rtl/lkers_checker.sv
// lkers_checker: port-level checks on the result channel of the search unit, bound to the top
// depends on lkers_pkg
`default_nettype none

module lkers_checker import lkers_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                empty,
	input wire logic                pop,
	input wire logic [STATUS_W-1:0] status,
	input wire logic [RES_W-1:0]    equal_count,
	input wire logic [RES_W-1:0]    first_index
);

	// no result word right after reset
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result shown straight after reset");

	// a stalled result word stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(status) && $stable(first_index))
		else $error("stalled result word changed");

	// only answers carry a match count
	a_count_zero: assert property (@(posedge clk)
		!empty && status != ST_ANSWERED |-> equal_count == '0)
		else $error("match count on a non-query word");

	// a dropped append reports a full table
	a_drop_full: assert property (@(posedge clk)
		!empty && status == ST_DROPPED |-> first_index == RES_W'(TABLE_DEPTH))
		else $error("append dropped below capacity");

	// the matching range lies inside the table
	a_range: assert property (@(posedge clk)
		!empty && status == ST_ANSWERED |->
		(TABLE_DEPTH >= 2048) ||
		((RES_W + 1)'(first_index) + (RES_W + 1)'(equal_count) <= (RES_W + 1)'(TABLE_DEPTH)))
		else $error("match range beyond table depth");

endmodule

bind linear_key_equal_range_search_unit lkers_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_lkers_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.status      (status),
	.equal_count (equal_count),
	.first_index (first_index)
);

`default_nettype wire
